FILE: hw/rtl/rmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmc_pkg
// Shared types and constants of the range membership counter: table depth,
// id width, stream layout, item kinds and result status codes.
// ----------------------------------------------------------------------------
package rmc_pkg;

  // table geometry
  localparam int unsigned MAX_RANGES = 256;
  localparam int unsigned ID_BITS    = 48;
  localparam int unsigned IDX_BITS   = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CNT_BITS   = $clog2(MAX_RANGES + 1);

  // running hit count
  localparam int unsigned TOTAL_BITS = 32;

  // stream layout, padded to whole bytes
  localparam int unsigned IN_FIELD_BITS  = 3 * ID_BITS;
  localparam int unsigned IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_FIELD_BITS = 1 + TOTAL_BITS + 1;
  localparam int unsigned OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // item kind carried in tuser
  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  // result status
  typedef enum logic [0:0] {
    ST_OK   = 1'b0,
    ST_FULL = 1'b1
  } status_e;

  // one stored range
  typedef struct packed {
    logic [ID_BITS-1:0] high;
    logic [ID_BITS-1:0] low;
  } range_t;

  // write port of the range table
  typedef struct packed {
    logic                en;
    logic [IDX_BITS-1:0] addr;
    range_t              data;
  } mem_wr_t;

  // read port of the range table
  typedef struct packed {
    logic                en;
    logic [IDX_BITS-1:0] addr;
  } mem_rd_t;

endpackage

FILE: hw/rtl/rmc_range_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmc_range_mem
// Range table storage: one write port and one read port with registered
// read data. Entries hold garbage until they are written.
// ----------------------------------------------------------------------------
module rmc_range_mem import rmc_pkg::*; (
  input  logic    clk_i,
  input  mem_wr_t wr_i,
  input  mem_rd_t rd_i,
  output range_t  rd_data_o
);

  range_t mem_q [MAX_RANGES];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_o <= mem_q[rd_i.addr];
    end
  end

endmodule

FILE: hw/rtl/rmc_match_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmc_match_unit
// Shared inclusive range compare, reused for each table entry scanned during a
// query. An inverted range can never satisfy both bounds.
// ----------------------------------------------------------------------------
module rmc_match_unit import rmc_pkg::*; (
  input  logic [ID_BITS-1:0] id_i,
  input  range_t             range_i,
  output logic               hit_o
);

  // low <= id <= high
  always_comb begin
    hit_o = (id_i >= range_i.low) && (id_i <= range_i.high);
  end

endmodule

FILE: hw/rtl/range_membership_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_membership_counter
// Table of inclusive id ranges with a saturating count of query hits.
// ----------------------------------------------------------------------------
// Flow: an accepted load goes through S_FIN to the result register; a query
// first scans in S_SCAN, reading 1 to ranges stored entries from the first
// and stopping at the first hit (no scan for an empty table). S_FIN holds
// while the result side stalls. One item at a time: none is taken outside
// S_IDLE. The scan reads one entry per cycle via the shared compare unit.
// Reset clears the range count, hit count and handshake state, not the table.
// ----------------------------------------------------------------------------
module range_membership_counter import rmc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input items
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [47:0] range_low, [95:48] range_high, [143:96] query_id
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // [0] opcode
  input  logic                     s_axis_tuser,
  // result items
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [0] matched, [32:1] match_total, [33] status, rest zero
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_BITS-1:0]   stored_q, stored_d;
  logic [TOTAL_BITS-1:0] total_q, total_d;
  logic [IDX_BITS-1:0]   idx_q, idx_d;
  logic [ID_BITS-1:0]    id_q, id_d;
  logic                  hit_q, hit_d;
  logic                  status_q, status_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_matched_q, out_matched_d;
  logic [TOTAL_BITS-1:0] out_total_q, out_total_d;
  logic                  out_status_q, out_status_d;

  logic                  in_fire;
  logic                  out_free;
  logic                  full;
  logic                  last_entry;
  logic                  cmp_hit;
  mem_wr_t               mem_wr;
  mem_rd_t               mem_rd;
  range_t                rd_range;
  range_t                in_range;
  logic [ID_BITS-1:0]    in_id;

  // input field unpacking
  assign in_range.low  = s_axis_tdata[ID_BITS-1:0];
  assign in_range.high = s_axis_tdata[2*ID_BITS-1:ID_BITS];
  assign in_id         = s_axis_tdata[3*ID_BITS-1:2*ID_BITS];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign full          = (stored_q == CNT_BITS'(MAX_RANGES));
  assign last_entry    = ((CNT_BITS'(idx_q) + CNT_BITS'(1)) == stored_q);

  // range table
  rmc_range_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_i      (mem_rd),
    .rd_data_o (rd_range)
  );

  // shared compare
  rmc_match_unit u_match (
    .id_i    (id_q),
    .range_i (rd_range),
    .hit_o   (cmp_hit)
  );

  // sequencer
  always_comb begin
    state_d       = state_q;
    stored_d      = stored_q;
    total_d       = total_q;
    idx_d         = idx_q;
    id_d          = id_q;
    hit_d         = hit_q;
    status_d      = status_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_matched_d = out_matched_q;
    out_total_d   = out_total_q;
    out_status_d  = out_status_q;
    mem_wr.en     = 1'b0;
    mem_wr.addr   = stored_q[IDX_BITS-1:0];
    mem_wr.data   = in_range;
    mem_rd.en     = 1'b0;
    mem_rd.addr   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          id_d   = in_id;
          hit_d  = 1'b0;
          idx_d  = '0;
          status_d = ST_OK;
          if (opcode_e'(s_axis_tuser) == OP_LOAD) begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              mem_wr.en = 1'b1;
              stored_d  = stored_q + CNT_BITS'(1);
            end
            state_d = S_FIN;
          end else if (stored_q == '0) begin
            state_d = S_FIN;
          end else begin
            mem_rd.en = 1'b1;
            state_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cmp_hit || last_entry) begin
          hit_d   = cmp_hit;
          state_d = S_FIN;
        end else begin
          mem_rd.en   = 1'b1;
          mem_rd.addr = idx_q + IDX_BITS'(1);
          idx_d       = idx_q + IDX_BITS'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          if (hit_q && (total_q != '1)) begin
            total_d = total_q + TOTAL_BITS'(1);
          end
          out_valid_d   = 1'b1;
          out_matched_d = hit_q;
          out_status_d  = status_q;
          out_total_d   = (hit_q && (total_q != '1)) ? total_q + TOTAL_BITS'(1) : total_q;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stored_q    <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stored_q    <= stored_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    id_q          <= id_d;
    hit_q         <= hit_d;
    status_q      <= status_d;
    out_matched_q <= out_matched_d;
    out_total_q   <= out_total_d;
    out_status_q  <= out_status_d;
  end

  // result packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_BITS'({out_status_q, out_total_q, out_matched_q});

endmodule

FILE: bench/range_match_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_match_checker
// Watches both streams of the range membership counter. It keeps its own
// range table and hit count and predicts one result item per accepted input
// item. Each result item is compared, field by field, with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module range_match_checker import rmc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input stream as seen by the block
  input  logic                     s_axis_tvalid,
  input  logic                     s_axis_tready,
  // [47:0] range_low, [95:48] range_high, [143:96] query_id
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // [0] opcode
  input  logic                     s_axis_tuser,
  // result stream as seen by the block
  input  logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [0] matched, [32:1] match_total, [33] status, rest zero
  input  logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  output int                       fail_count_o,
  output int                       pending_o
);

  localparam int unsigned PAD_BITS = OUT_DATA_BITS - OUT_FIELD_BITS;

  typedef struct packed {
    logic                  matched;
    logic [TOTAL_BITS-1:0] total;
    status_e               status;
  } result_t;

  // shadow copy of the block state
  range_t                range_tab [MAX_RANGES];
  int unsigned           ranges_held;
  logic [TOTAL_BITS-1:0] hit_count;

  result_t               expected_results [$];
  int                    mismatches;

  // apply one item to the shadow state and return its result
  function automatic result_t predict_result(opcode_e op, logic [ID_BITS-1:0] lo,
                                             logic [ID_BITS-1:0] hi,
                                             logic [ID_BITS-1:0] id);
    result_t res;
    logic    hit;
    res.matched = 1'b0;
    res.status  = ST_OK;
    hit         = 1'b0;
    if (op == OP_LOAD) begin
      if (ranges_held < MAX_RANGES) begin
        range_tab[ranges_held].low  = lo;
        range_tab[ranges_held].high = hi;
        ranges_held++;
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      // only written entries take part; an inverted range never matches
      for (int i = 0; i < ranges_held; i++) begin
        if (id >= range_tab[i].low && id <= range_tab[i].high) hit = 1'b1;
      end
      if (hit) begin
        res.matched = 1'b1;
        if (hit_count != '1) hit_count++;
      end
    end
    res.total = hit_count;
    return res;
  endfunction

  // compare result items first, then record the new input item
  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t             exp_res;
    result_t             got_res;
    result_t             pred_res;
    logic [PAD_BITS-1:0] got_pad;
    if (!rst_ni) begin
      ranges_held = 0;
      hit_count   = '0;
      mismatches  = 0;
      expected_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res.matched = m_axis_tdata[0];
        got_res.total   = m_axis_tdata[TOTAL_BITS:1];
        got_res.status  = status_e'(m_axis_tdata[TOTAL_BITS+1]);
        got_pad         = m_axis_tdata[OUT_DATA_BITS-1:OUT_FIELD_BITS];
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result item: matched=%0b total=%0d status=%0b",
                     $time, got_res.matched, got_res.total, got_res.status);
          mismatches++;
        end else begin
          exp_res = expected_results.pop_front();
          if (got_res.matched !== exp_res.matched || got_res.total !== exp_res.total ||
              got_res.status !== exp_res.status || got_pad !== '0) begin
            if (mismatches < 10) begin
              $display("%0t: result mismatch: expected matched=%0b total=%0d status=%0b pad=0",
                       $time, exp_res.matched, exp_res.total, exp_res.status);
              $display("%0t:   got matched=%0b total=%0d status=%0b pad=%0h",
                       $time, got_res.matched, got_res.total, got_res.status, got_pad);
            end
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pred_res = predict_result(opcode_e'(s_axis_tuser),
                                  s_axis_tdata[ID_BITS-1:0],
                                  s_axis_tdata[2*ID_BITS-1:ID_BITS],
                                  s_axis_tdata[3*ID_BITS-1:2*ID_BITS]);
        expected_results.insert(expected_results.size(), pred_res);
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_results.size();
    end
  end

endmodule

FILE: bench/tb_range_membership_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_membership_counter
// Drives loads and queries into the range membership counter: a directed
// pass over bound extremes, inverted ranges and an empty table, then random
// loads and queries that fill the table past full, with queries aimed at and
// around stored bounds. Both sides stall in random bursts. The checker does
// the prediction; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_range_membership_counter;
  import rmc_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 550;
  localparam int unsigned QUIET_ITEMS    = 80;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam logic [ID_BITS-1:0] ID_MAX  = '1;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
  logic                     s_axis_tuser  = 1'b0;
  logic                     m_axis_tready = 1'b0;
  logic                     s_axis_tready;
  logic                     m_axis_tvalid;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  int                       fail_count;
  int                       pending;

  int unsigned tx_gap_pct    = 0;
  int unsigned rx_stall_pct  = 0;
  int unsigned rx_stall_left = 0;

  // ranges the block should hold, used to aim queries
  range_t      loaded [$];
  int unsigned loads_sent = 0;

  range_membership_counter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  range_match_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side backpressure in random bursts
  always @(posedge clk_i) begin
    if (rx_stall_left != 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
      m_axis_tready <= 1'b0;
      rx_stall_left <= $urandom_range(1, 15) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [ID_BITS-1:0] rand_id();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ID_BITS-1:0];
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  // base + span, clipped at the largest id
  function automatic logic [ID_BITS-1:0] clip_add(logic [ID_BITS-1:0] base,
                                                  logic [ID_BITS-1:0] span);
    logic [ID_BITS:0] sum;
    sum = {1'b0, base} + {1'b0, span};
    return sum[ID_BITS] ? ID_MAX : sum[ID_BITS-1:0];
  endfunction

  // mostly narrow ranges so that misses stay common
  function automatic range_t rand_range();
    logic [ID_BITS-1:0] a;
    logic [ID_BITS-1:0] b;
    logic [63:0]        r;
    range_t             rg;
    a = rand_id();
    b = rand_id();
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1:    b = a;
      2, 3, 4: b = clip_add(a, ID_BITS'($urandom_range(0, 15)));
      5, 6:    b = clip_add(a, ID_BITS'($urandom_range(0, 1 << 20)));
      7:       b = clip_add(a, ID_BITS'(r[39:0]));
      default: begin
        // inverted: low bound above high bound
        if (a < b) begin
          rg.low  = b;
          rg.high = a;
          return rg;
        end
      end
    endcase
    rg.low  = a;
    rg.high = b;
    return rg;
  endfunction

  // ids on, just outside and inside stored ranges, some fully random
  function automatic logic [ID_BITS-1:0] pick_query_id();
    range_t      rg;
    logic [63:0] r;
    logic [63:0] span;
    logic [63:0] off;
    if (loaded.size() == 0 || $urandom_range(0, 9) < 3) return rand_id();
    rg = loaded[$urandom_range(0, loaded.size() - 1)];
    case ($urandom_range(0, 4))
      0:       return rg.low;
      1:       return rg.high;
      2:       return rg.low - 1'b1;
      3:       return rg.high + 1'b1;
      default: begin
        if (rg.high < rg.low) return rg.low;
        r    = {$urandom, $urandom};
        span = {16'b0, rg.high} - {16'b0, rg.low} + 64'd1;
        off  = r % span;
        return rg.low + off[ID_BITS-1:0];
      end
    endcase
  endfunction

  // present one item and hold it until accepted
  task automatic send_item(opcode_e op, logic [ID_BITS-1:0] lo, logic [ID_BITS-1:0] hi,
                           logic [ID_BITS-1:0] id);
    range_t rg;
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {id, hi, lo};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_LOAD) begin
      loads_sent++;
      if (loaded.size() < MAX_RANGES) begin
        rg.low  = lo;
        rg.high = hi;
        loaded.insert(loaded.size(), rg);
      end
    end
  endtask

  // stop sending until every result item is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // stimulus and verdict
  initial begin : stimulus
    int unsigned n;
    range_t      rg;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    tx_gap_pct   = 20;
    rx_stall_pct = 20;

    // empty table
    send_item(OP_QUERY, rand_id(), rand_id(), '0);
    send_item(OP_QUERY, rand_id(), rand_id(), ID_MAX);
    // extremes as single points, an inverted range and a plain one
    send_item(OP_LOAD, '0, '0, ID_MAX);
    send_item(OP_LOAD, ID_MAX, ID_MAX, '0);
    send_item(OP_LOAD, 48'd100, 48'd50, rand_id());
    send_item(OP_LOAD, 48'd1000, 48'd2000, rand_id());
    send_item(OP_QUERY, ID_MAX, '0, '0);
    send_item(OP_QUERY, '0, ID_MAX, ID_MAX);
    send_item(OP_QUERY, rand_id(), rand_id(), 48'd1);
    send_item(OP_QUERY, rand_id(), rand_id(), ID_MAX - 1'b1);
    send_item(OP_QUERY, rand_id(), rand_id(), 48'd50);
    send_item(OP_QUERY, rand_id(), rand_id(), 48'd75);
    send_item(OP_QUERY, rand_id(), rand_id(), 48'd100);
    send_item(OP_QUERY, rand_id(), rand_id(), 48'd999);
    send_item(OP_QUERY, rand_id(), rand_id(), 48'd1000);
    send_item(OP_QUERY, rand_id(), rand_id(), 48'd2000);
    send_item(OP_QUERY, rand_id(), rand_id(), 48'd2001);
    send_item(OP_QUERY, rand_id(), rand_id(), 48'd1500);
    wait_drained();

    // random loads and queries; loads past a full table get dropped
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        tx_gap_pct   = pick_pct();
        rx_stall_pct = pick_pct();
      end
      if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end
      if (n == RANDOM_ITEMS / 2) wait_drained();
      if ($urandom_range(0, 99) < ((loads_sent < MAX_RANGES + 8) ? 60 : 8)) begin
        rg = rand_range();
        send_item(OP_LOAD, rg.low, rg.high, rand_id());
      end else begin
        send_item(OP_QUERY, rand_id(), rand_id(), pick_query_id());
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // end the run when nothing moves for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
